FILE: rtl/cbq_pkg.sv
// Shared types and constants for the cascaded biquad IIR filter.
// No dependencies; every RTL file of the block uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cbq_pkg;

  localparam int SAMPLE_W         = 24;
  localparam int COEF_W           = 32;
  localparam int PROD_W           = SAMPLE_W + COEF_W;
  localparam int ACC_W            = PROD_W + 2;
  localparam int ROUND_SHIFT      = 30;
  localparam int NUM_SLOTS        = 5;
  localparam int NUM_SECTIONS_DEF = 8;
  localparam int SECTION_IDX_W    = 3;
  localparam int SLOT_IDX_W       = 3;

  typedef enum logic [0:0] {
    CMD_FILTER = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_t;

  // Phases of one section: read issue, five products in flight, accumulate, close.
  typedef enum logic [2:0] {
    PH_ISSUE = 3'd0,
    PH_B0    = 3'd1,
    PH_B1    = 3'd2,
    PH_B2    = 3'd3,
    PH_A1    = 3'd4,
    PH_A2    = 3'd5,
    PH_ACC   = 3'd6,
    PH_CLOSE = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Delay line of one section.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } dly_entry_t;

endpackage

`default_nettype wire

FILE: rtl/cascaded_biquad_iir_filter_top.sv
// Cascaded biquad IIR filter, direct form I, with coefficient and delay memories.
// Depends on cbq_pkg.
//
// Each request either writes one coefficient (stored on acceptance, no result) or
// filters one Q1.23 sample through NUM_SECTIONS second-order sections with Q2.30
// coefficients. One shared 32x24 multiplier and a 58-bit accumulator work through
// the sections in turn; each section steps through memory read, five products,
// accumulate, round/saturate and delay write-back. After the last section the
// result is registered at the output once the output register is free, and the
// next request is taken from then on, even if that result is still stalled.
// After reset a clearing pass walks the 5*NUM_SECTIONS coefficient addresses and
// zeroes the coefficient and delay memories; no request is taken during it.
// out_clipped flags that at least one section output saturated for that sample.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_biquad_iir_filter_top #(
  parameter int NUM_SECTIONS = cbq_pkg::NUM_SECTIONS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire  [0:0]                              in_command,
  input  wire  signed [cbq_pkg::SAMPLE_W-1:0]     in_sample_in,
  input  wire  [cbq_pkg::SECTION_IDX_W-1:0]       in_coef_section,
  input  wire  [cbq_pkg::SLOT_IDX_W-1:0]          in_coef_slot,
  input  wire  signed [cbq_pkg::COEF_W-1:0]       in_coef_value,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]     out_sample_out,
  output logic                                    out_clipped
);

  localparam int COEF_DEPTH = cbq_pkg::NUM_SLOTS * NUM_SECTIONS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int SA_W       = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int SW         = cbq_pkg::SAMPLE_W;
  localparam int CW         = cbq_pkg::COEF_W;
  localparam int PW         = cbq_pkg::PROD_W;
  localparam int AW         = cbq_pkg::ACC_W;
  localparam int YW         = AW - cbq_pkg::ROUND_SHIFT;
  localparam int SEC_CMP_W  = cbq_pkg::SECTION_IDX_W + 4;

  localparam logic [CA_W-1:0]      COEF_LAST  = CA_W'(COEF_DEPTH - 1);
  localparam logic [CA_W-1:0]      SEC_LIM_CA = CA_W'(NUM_SECTIONS);
  localparam logic [SA_W-1:0]      SEC_LAST   = SA_W'(NUM_SECTIONS - 1);
  localparam logic [SEC_CMP_W-1:0] SEC_LIM    = SEC_CMP_W'(NUM_SECTIONS);
  localparam logic signed [AW-1:0] RND_BIAS   = AW'(64'd1 << (cbq_pkg::ROUND_SHIFT - 1));
  localparam logic signed [SW-1:0] Y_MAX      = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] Y_MIN      = {1'b1, {(SW-1){1'b0}}};

  // Memories
  logic [CW-1:0]            coef_mem [COEF_DEPTH];
  cbq_pkg::dly_entry_t      dly_mem  [NUM_SECTIONS];

  // Control
  cbq_pkg::state_t          state_r, state_nxt;
  cbq_pkg::phase_t          phase_r;
  logic [CA_W-1:0]          clr_r;
  logic [CA_W-1:0]          coef_addr_r;
  logic [SA_W-1:0]          sec_r;
  logic                     out_valid_r;

  // Datapath
  logic signed [CW-1:0]     coef_rd_r;
  cbq_pkg::dly_entry_t      dly_rd_r;
  logic signed [SW-1:0]     x_r;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic signed [AW-1:0]     acc_r, acc_nxt;
  logic                     clip_r;
  logic signed [SW-1:0]     out_sample_r;
  logic                     out_clipped_r;

  logic                     in_req;
  logic                     coef_cmd;
  logic                     coef_ok;
  logic [CA_W-1:0]          coef_waddr;
  logic                     coef_we;
  logic [CA_W-1:0]          coef_wa;
  logic [CW-1:0]            coef_wd;
  logic                     dly_we;
  logic [SA_W-1:0]          dly_wa;
  cbq_pkg::dly_entry_t      dly_wd;
  logic signed [SW-1:0]     mul_op;
  logic signed [AW-1:0]     rnd_sum;
  logic signed [YW-1:0]     y_wide;
  logic signed [SW-1:0]     y_sat;
  logic                     y_ovf;
  logic                     out_free;
  logic                     sec_last;

  assign in_stall = (state_r != cbq_pkg::ST_IDLE);
  assign in_req   = in_valid && !in_stall;
  assign coef_cmd = (in_command == cbq_pkg::CMD_COEF);
  assign coef_ok  = ({4'b0, in_coef_section} < SEC_LIM) &&
                    (in_coef_slot < cbq_pkg::SLOT_IDX_W'(cbq_pkg::NUM_SLOTS));
  assign coef_waddr = CA_W'(in_coef_section * cbq_pkg::NUM_SLOTS) + CA_W'(in_coef_slot);
  assign out_free   = !out_valid_r || !out_stall;
  assign sec_last   = (sec_r == SEC_LAST);

  // Memory write ports
  always_comb begin
    coef_we = 1'b0;
    coef_wa = clr_r;
    coef_wd = '0;
    dly_we  = 1'b0;
    dly_wa  = sec_r;
    dly_wd  = '{x1: x_r, x2: dly_rd_r.x1, y1: y_sat, y2: dly_rd_r.y1};
    if (state_r == cbq_pkg::ST_CLEAR) begin
      coef_we = 1'b1;
      dly_we  = (clr_r < SEC_LIM_CA);
      dly_wa  = clr_r[SA_W-1:0];
      dly_wd  = '0;
    end else if (in_req && coef_cmd) begin
      coef_we = coef_ok;
      coef_wa = coef_waddr;
      coef_wd = in_coef_value;
    end else if (state_r == cbq_pkg::ST_RUN && phase_r == cbq_pkg::PH_CLOSE) begin
      dly_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_r <= coef_mem[coef_addr_r];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_rd_r <= dly_mem[sec_r];
  end

  // Multiply-accumulate
  always_comb begin
    case (phase_r)
      cbq_pkg::PH_B0: mul_op = x_r;
      cbq_pkg::PH_B1: mul_op = dly_rd_r.x1;
      cbq_pkg::PH_B2: mul_op = dly_rd_r.x2;
      cbq_pkg::PH_A1: mul_op = dly_rd_r.y1;
      cbq_pkg::PH_A2: mul_op = dly_rd_r.y2;
      default:        mul_op = '0;
    endcase
  end

  assign prod_nxt = coef_rd_r * mul_op;

  always_comb begin
    case (phase_r)
      cbq_pkg::PH_B1:  acc_nxt = AW'(prod_r);
      cbq_pkg::PH_B2,
      cbq_pkg::PH_A1:  acc_nxt = acc_r + AW'(prod_r);
      cbq_pkg::PH_A2,
      cbq_pkg::PH_ACC: acc_nxt = acc_r - AW'(prod_r);
      default:         acc_nxt = acc_r;
    endcase
  end

  // Round half up, floor shift, saturate
  assign rnd_sum = acc_r + RND_BIAS;
  assign y_wide  = rnd_sum[AW-1:cbq_pkg::ROUND_SHIFT];
  assign y_ovf   = (y_wide[YW-1:SW-1] != {(YW-SW+1){1'b0}}) &&
                   (y_wide[YW-1:SW-1] != {(YW-SW+1){1'b1}});

  always_comb begin
    if (!y_ovf) begin
      y_sat = y_wide[SW-1:0];
    end else if (y_wide[YW-1]) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = Y_MAX;
    end
  end

  // State machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbq_pkg::ST_CLEAR: begin
        if (clr_r == COEF_LAST) begin
          state_nxt = cbq_pkg::ST_IDLE;
        end
      end
      cbq_pkg::ST_IDLE: begin
        if (in_req && !coef_cmd) begin
          state_nxt = cbq_pkg::ST_RUN;
        end
      end
      cbq_pkg::ST_RUN: begin
        if (phase_r == cbq_pkg::PH_CLOSE && sec_last) begin
          state_nxt = cbq_pkg::ST_DONE;
        end
      end
      cbq_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cbq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbq_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbq_pkg::ST_CLEAR;
      phase_r     <= cbq_pkg::PH_ISSUE;
      clr_r       <= '0;
      coef_addr_r <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cbq_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (in_req && !coef_cmd) begin
        phase_r     <= cbq_pkg::PH_ISSUE;
        coef_addr_r <= '0;
        sec_r       <= '0;
      end else if (state_r == cbq_pkg::ST_RUN) begin
        phase_r <= cbq_pkg::phase_t'(phase_r + 3'd1);
        if (phase_r <= cbq_pkg::PH_A1 && coef_addr_r != COEF_LAST) begin
          coef_addr_r <= coef_addr_r + 1'b1;
        end
        if (phase_r == cbq_pkg::PH_CLOSE && !sec_last) begin
          sec_r <= sec_r + 1'b1;
        end
      end
      if (state_r == cbq_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (in_req && !coef_cmd) begin
      x_r    <= in_sample_in;
      clip_r <= 1'b0;
    end else if (state_r == cbq_pkg::ST_RUN && phase_r == cbq_pkg::PH_CLOSE) begin
      x_r    <= y_sat;
      clip_r <= clip_r | y_ovf;
    end
    if (state_r == cbq_pkg::ST_DONE && out_free) begin
      out_sample_r  <= x_r;
      out_clipped_r <= clip_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= SEC_LAST)
    else $error("section index beyond last section");

  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cbq_pkg::ST_RUN) |=> (phase_r == cbq_pkg::PH_ISSUE))
    else $error("phase counter moved outside a run");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == cbq_pkg::ST_DONE))
    else $error("result presented without finishing all sections");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbq_pkg::ST_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == cbq_pkg::ST_DONE) |-> ($past(sec_r) == SEC_LAST))
    else $error("run ended before last section");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the cascaded biquad IIR filter top level.
// Depends on cbq_pkg and cascaded_biquad_iir_filter_top; predicts each filtered
// sample in fixed point and compares it with the block's output stream.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_SEC = cbq_pkg::NUM_SECTIONS_DEF;
  localparam int SW = cbq_pkg::SAMPLE_W;
  localparam int CW = cbq_pkg::COEF_W;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic signed [CW-1:0] COEF_ONE = 32'sh4000_0000;
  localparam logic signed [CW-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] COEF_MIN = 32'sh8000_0000;
  localparam logic signed [SW-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
  localparam logic signed [SW-1:0] SAMPLE_MIN = 24'sh80_0000;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8 * NUM_SEC + 8;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clip;
  } filtered_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [0:0] in_command = cbq_pkg::CMD_FILTER;
  logic signed [SW-1:0] in_sample_in = '0;
  logic [cbq_pkg::SECTION_IDX_W-1:0] in_coef_section = '0;
  logic [cbq_pkg::SLOT_IDX_W-1:0] in_coef_slot = '0;
  logic signed [CW-1:0] in_coef_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_sample_out;
  logic out_clipped;

  logic hold_active = 1'b0;
  logic quiet_run = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int items_sent = 0;

  logic signed [CW-1:0] coef_mem [0:5*NUM_SEC-1] = '{default: '0};
  logic signed [SW-1:0] x_dly [0:2*NUM_SEC-1] = '{default: '0};
  logic signed [SW-1:0] y_dly [0:2*NUM_SEC-1] = '{default: '0};
  filtered_t filtered_due [$];

  wire in_fire = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  cascaded_biquad_iir_filter_top #(
    .NUM_SECTIONS(NUM_SEC)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_sample_in   (in_sample_in),
    .in_coef_section(in_coef_section),
    .in_coef_slot   (in_coef_slot),
    .in_coef_value  (in_coef_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic filtered_t run_cascade(input logic signed [SW-1:0] sample);
    filtered_t res;
    longint acc;
    longint xv;
    longint yv;
    res.clip = 1'b0;
    xv = longint'(sample);
    for (int s = 0; s < NUM_SEC; s++) begin
      acc = longint'(coef_mem[5*s]) * xv
          + longint'(coef_mem[5*s+1]) * longint'(x_dly[2*s])
          + longint'(coef_mem[5*s+2]) * longint'(x_dly[2*s+1])
          - longint'(coef_mem[5*s+3]) * longint'(y_dly[2*s])
          - longint'(coef_mem[5*s+4]) * longint'(y_dly[2*s+1]);
      yv = (acc + (longint'(1) << 29)) >>> 30;
      if (yv > longint'(SAMPLE_MAX)) begin
        yv = longint'(SAMPLE_MAX);
        res.clip = 1'b1;
      end
      if (yv < longint'(SAMPLE_MIN)) begin
        yv = longint'(SAMPLE_MIN);
        res.clip = 1'b1;
      end
      x_dly[2*s+1] = x_dly[2*s];
      x_dly[2*s] = xv[SW-1:0];
      y_dly[2*s+1] = y_dly[2*s];
      y_dly[2*s] = yv[SW-1:0];
      xv = yv;
    end
    res.sample = xv[SW-1:0];
    return res;
  endfunction

  // Track accepted requests and score each returned sample.
  always @(posedge clk) begin : scoreboard
    filtered_t want;
    if (rst_n && in_fire) begin
      if (in_command == cbq_pkg::CMD_COEF) begin
        if (in_coef_slot < cbq_pkg::NUM_SLOTS && in_coef_section < NUM_SEC)
          coef_mem[in_coef_section * 5 + in_coef_slot] = in_coef_value;
      end else begin
        filtered_due.push_back(run_cascade(in_sample_in));
      end
    end
    if (rst_n && out_fire) begin
      if (filtered_due.size() == 0) begin
        $display("%0t: unexpected output: expected none, actual sample %0d clipped %0b",
                 $time, out_sample_out, out_clipped);
        fail_count++;
      end else begin
        want = filtered_due.pop_front();
        if (out_sample_out !== want.sample) begin
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want.sample, out_sample_out);
          fail_count++;
        end
        if (out_clipped !== want.clip) begin
          $display("%0t: clipped mismatch: expected %0b, actual %0b",
                   $time, want.clip, out_clipped);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no request moved for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver side: long hold-off on request, random short bursts unless quiet_run.
  always @(negedge clk) begin
    if (hold_active) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(input logic [0:0] cmd, input logic signed [SW-1:0] smp,
                              input logic [2:0] sec, input logic [2:0] slot,
                              input logic signed [CW-1:0] val);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample_in <= smp;
    in_coef_section <= sec;
    in_coef_slot <= slot;
    in_coef_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (cmd == cbq_pkg::CMD_FILTER || slot < cbq_pkg::NUM_SLOTS)
      items_sent++;
    @(negedge clk);
  endtask

  task automatic write_coef(input logic [2:0] sec, input logic [2:0] slot,
                            input logic signed [CW-1:0] val);
    send_request(cbq_pkg::CMD_COEF, SW'($urandom), sec, slot, val);
  endtask

  task automatic filter_sample(input logic signed [SW-1:0] smp);
    send_request(cbq_pkg::CMD_FILTER, smp, 3'($urandom), 3'($urandom), CW'($urandom));
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    logic signed [SW-1:0] v;
    v = SW'($urandom);
    if ($urandom_range(0, 3) == 0)
      v = v >>> $urandom_range(4, 20);
    return v;
  endfunction

  function automatic logic signed [CW-1:0] rand_coef(input int bits);
    logic signed [CW-1:0] v;
    v = CW'($urandom);
    return v >>> (31 - bits);
  endfunction

  // Poles well inside the unit circle: |a1| <= 0.5, |a2| <= 0.25.
  task automatic program_stable_section(input logic [2:0] sec);
    write_coef(sec, SLOT_B0, rand_coef(29));
    write_coef(sec, SLOT_B1, rand_coef(28));
    write_coef(sec, SLOT_B2, rand_coef(28));
    write_coef(sec, SLOT_A1, rand_coef(29));
    write_coef(sec, SLOT_A2, rand_coef(28));
  endtask

  task automatic test_cleared_state();
    filter_sample(SAMPLE_MAX);
    filter_sample(SAMPLE_MIN);
    filter_sample(24'sd1);
  endtask

  task automatic test_unity_cascade();
    for (int s = 0; s < NUM_SEC; s++)
      write_coef(3'(s), SLOT_B0, COEF_ONE);
    filter_sample(SAMPLE_MAX);
    filter_sample(SAMPLE_MIN);
    filter_sample(-24'sd1);
    filter_sample(24'sd0);
  endtask

  task automatic test_saturation();
    write_coef(3'd0, SLOT_B0, COEF_MAX);
    filter_sample(SAMPLE_MAX);
    filter_sample(SAMPLE_MIN);
    write_coef(3'd0, SLOT_B0, COEF_MIN);
    filter_sample(SAMPLE_MIN);
  endtask

  task automatic test_ignored_writes();
    for (int k = cbq_pkg::NUM_SLOTS; k < 8; k++)
      write_coef(3'(k), 3'(k), COEF_MAX);
    filter_sample(SAMPLE_MAX);
  endtask

  task automatic test_output_backpressure();
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active <= 1'b0;
      end
      for (int i = 0; i < 12; i++)
        filter_sample(rand_sample());
    join
  endtask

  task automatic test_random_traffic(input int n_items);
    int target;
    int kind;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        repeat ($urandom_range(1, NUM_SEC))
          program_stable_section(3'($urandom_range(0, NUM_SEC - 1)));
        repeat ($urandom_range(5, 30))
          filter_sample(rand_sample());
      end else if (kind < 8) begin
        write_coef(3'($urandom), 3'($urandom), CW'($urandom));
        repeat ($urandom_range(1, 6))
          filter_sample(rand_sample());
      end else begin
        repeat ($urandom_range(1, 8))
          send_request(1'($urandom), SW'($urandom), 3'($urandom), 3'($urandom),
                       CW'($urandom));
      end
    end
  endtask

  task automatic test_steady_stream();
    quiet_run <= 1'b1;
    for (int s = 0; s < NUM_SEC; s++)
      program_stable_section(3'(s));
    repeat (60)
      filter_sample(rand_sample());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_cleared_state();
    test_unity_cascade();
    test_saturation();
    test_ignored_writes();
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    test_steady_stream();
    in_valid <= 1'b0;
    while (filtered_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: cascaded_biquad_iir_filter_top.f
rtl/cbq_pkg.sv
rtl/cascaded_biquad_iir_filter_top.sv
sim/tb_top.sv
